### rtl/kvm_pkg.sv
// shared types and codes for the compensated vector-matrix product block
// no dependencies
package kvm_pkg;

  localparam logic [1:0] ACT_LOAD_VEC = 2'd0;
  localparam logic [1:0] ACT_LOAD_MAT = 2'd1;
  localparam logic [1:0] ACT_COMPUTE  = 2'd2;

  localparam logic [1:0] CFG_INNER_LEN   = 2'd0;
  localparam logic [1:0] CFG_MATRIX_ROWS = 2'd1;
  localparam logic [1:0] CFG_OUT_LEN     = 2'd2;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

  typedef enum logic {
    FPU_MUL,
    FPU_ADD
  } fpu_op_t;

  typedef struct packed {
    logic        valid;
    fpu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } fpu_rsp_t;

endpackage

### rtl/kvm_in_if.sv
// input channel: load and compute transactions
// no dependencies
interface kvm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [5:0]  row_index;
  logic [5:0]  col_index;
  logic [31:0] value_bits;

  modport source (output valid, action, row_index, col_index, value_bits, input ready);
  modport sink (input valid, action, row_index, col_index, value_bits, output ready);
endinterface

### rtl/kvm_out_if.sv
// result channel: one transaction per output column
// no dependencies
interface kvm_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  out_index;
  logic [31:0] out_value;
  logic        last;
  logic        mismatch;

  modport source (output valid, out_index, out_value, last, mismatch, input ready);
  modport sink (input valid, out_index, out_value, last, mismatch, output ready);
endinterface

### rtl/kahan_vector_matrix_product.sv
// top level: operand memories, Kahan summation sequencer and result register
// depends on kvm_pkg, kvm_in_if, kvm_out_if and kvm_fpu
//
// Loads a row vector and a matrix of binary32 values one element per input
// transaction and, on a compute transaction, returns one Kahan-compensated
// dot product per matrix column. Operands sit in two single-port memories
// with registered reads. All arithmetic goes through one shared two-stage
// multiply/add unit, and each term of a column needs one multiply and four
// dependent adds. No new transaction is taken until the last column has been
// handed to the output register. A length mismatch sends the sequencer to its
// emit state, which puts a single flagged result in the output register once
// that register is free.
module kahan_vector_matrix_product
  import kvm_pkg::*;
#(
  parameter int MAX_N = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  kvm_in_if.sink     in_chan,
  kvm_out_if.source  out_chan,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_wdata
);

  localparam int AW      = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int MW      = $clog2(MAX_N * MAX_N);
  localparam int KW      = $clog2(MAX_N + 1);
  localparam int OUT_CAP = (MAX_N < 64) ? MAX_N : 64;

  typedef enum logic [3:0] {
    S_IDLE, S_COL, S_NEXT, S_MUL, S_WMUL, S_WY, S_WT, S_WD, S_WC, S_EMIT, S_DONE
  } state_t;

  state_t      state_r;
  logic [6:0]  inner_len_r, matrix_rows_r, out_len_r;
  logic [KW-1:0] n_r, k_r;
  logic [6:0]  cols_r, j_r;
  logic        mis_r;
  logic [31:0] s_r, c_r, y_r, t_r;
  logic        out_valid_r;
  logic [5:0]  out_index_r;
  logic [31:0] out_value_r;
  logic        out_last_r, out_mis_r;

  logic [31:0] vec_mem [MAX_N];
  logic [31:0] mat_mem [MAX_N * MAX_N];
  logic [31:0] vdata_r, mdata_r;

  fpu_req_t    req;
  fpu_rsp_t    rsp;

  logic        in_acc;
  logic        vec_we, mat_we, rd_en;
  logic [AW-1:0] vec_waddr;
  logic [MW-1:0] mat_waddr, mat_raddr;
  logic        out_free;
  logic        emit_last;
  logic [31:0] s_canon;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign vec_we    = in_acc && (in_chan.action == ACT_LOAD_VEC) && (32'(in_chan.row_index) < MAX_N);
  assign mat_we    = in_acc && (in_chan.action == ACT_LOAD_MAT) &&
                     (32'(in_chan.row_index) < MAX_N) && (32'(in_chan.col_index) < MAX_N);
  assign vec_waddr = AW'(in_chan.row_index);
  assign mat_waddr = MW'(32'(in_chan.row_index) * MAX_N + 32'(in_chan.col_index));
  assign mat_raddr = MW'(32'(k_r) * MAX_N + 32'(j_r));
  assign rd_en     = (state_r == S_NEXT) && (k_r != n_r);

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_waddr] <= in_chan.value_bits;
    end
    if (rd_en) begin
      vdata_r <= vec_mem[k_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= in_chan.value_bits;
    end
    if (rd_en) begin
      mdata_r <= mat_mem[mat_raddr];
    end
  end

  // one multiply and four adds per term
  always_comb begin
    req.valid = 1'b0;
    req.op    = FPU_ADD;
    req.a     = rsp.result;
    req.b     = 32'd0;
    case (state_r)
      S_MUL: begin
        req.valid = 1'b1;
        req.op    = FPU_MUL;
        req.a     = vdata_r;
        req.b     = mdata_r;
      end
      S_WMUL: begin
        req.valid = rsp.done;
        req.b     = {~c_r[31], c_r[30:0]};
      end
      S_WY: begin
        req.valid = rsp.done;
        req.a     = s_r;
        req.b     = rsp.result;
      end
      S_WT: begin
        req.valid = rsp.done;
        req.b     = {~s_r[31], s_r[30:0]};
      end
      S_WD: begin
        req.valid = rsp.done;
        req.b     = {~y_r[31], y_r[30:0]};
      end
      default: begin
        req.valid = 1'b0;
      end
    endcase
  end

  kvm_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign out_free  = !out_valid_r || out_chan.ready;
  assign emit_last = mis_r || (j_r + 7'd1 == cols_r);
  assign s_canon   = ((s_r[30:23] == 8'hFF) && (s_r[22:0] != 23'd0)) ? QNAN_BITS : s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      inner_len_r   <= 7'd64;
      matrix_rows_r <= 7'd64;
      out_len_r     <= 7'd64;
      out_valid_r   <= 1'b0;
      mis_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INNER_LEN:   inner_len_r   <= cfg_wdata;
          CFG_MATRIX_ROWS: matrix_rows_r <= cfg_wdata;
          CFG_OUT_LEN:     out_len_r     <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_chan.action == ACT_COMPUTE)) begin
            j_r    <= 7'd0;
            n_r    <= (32'(inner_len_r) > MAX_N) ? KW'(MAX_N) : KW'(inner_len_r);
            cols_r <= (32'(out_len_r) > OUT_CAP) ? 7'(OUT_CAP) : out_len_r;
            if (inner_len_r != matrix_rows_r) begin
              mis_r   <= 1'b1;
              state_r <= S_EMIT;
            end else begin
              mis_r   <= 1'b0;
              state_r <= (out_len_r == 7'd0) ? S_DONE : S_COL;
            end
          end
        end
        S_COL: begin
          s_r     <= 32'd0;
          c_r     <= 32'd0;
          k_r     <= '0;
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          state_r <= (k_r == n_r) ? S_EMIT : S_MUL;
        end
        S_MUL: begin
          state_r <= S_WMUL;
        end
        S_WMUL: begin
          if (rsp.done) begin
            state_r <= S_WY;
          end
        end
        S_WY: begin
          if (rsp.done) begin
            y_r     <= rsp.result;
            state_r <= S_WT;
          end
        end
        S_WT: begin
          if (rsp.done) begin
            t_r     <= rsp.result;
            state_r <= S_WD;
          end
        end
        S_WD: begin
          if (rsp.done) begin
            state_r <= S_WC;
          end
        end
        S_WC: begin
          if (rsp.done) begin
            c_r     <= rsp.result;
            s_r     <= t_r;
            k_r     <= k_r + KW'(1);
            state_r <= S_NEXT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_index_r <= mis_r ? 6'd0 : j_r[5:0];
            out_value_r <= mis_r ? 32'd0 : s_canon;
            out_last_r  <= emit_last;
            out_mis_r   <= mis_r;
            j_r         <= j_r + 7'd1;
            state_r     <= emit_last ? S_IDLE : S_COL;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_index = out_index_r;
  assign out_chan.out_value = out_value_r;
  assign out_chan.last      = out_last_r;
  assign out_chan.mismatch  = out_mis_r;

endmodule

### rtl/kvm_fpu.sv
// two-stage binary32 multiply / add unit, round to nearest even
// depends on kvm_pkg
module kvm_fpu
  import kvm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  fpu_req_t req,
  output fpu_rsp_t rsp
);

  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] e_in,
                                             input logic [23:0] mant, input logic g,
                                             input logic st);
    logic              up;
    logic [24:0]       m25;
    logic [23:0]       m;
    logic signed [11:0] e;
    logic [31:0]       res;
    up  = g & (st | mant[0]);
    m25 = {1'b0, mant} + {24'd0, up};
    e   = e_in;
    if (m25[24]) begin
      m = m25[24:1];
      e = e + 12'sd1;
    end else begin
      m = m25[23:0];
    end
    if (e >= 12'sd255) begin
      res = {sgn, 8'hFF, 23'd0};
    end else begin
      res = {sgn, (m[23] ? e[7:0] : 8'd0), m[22:0]};
    end
    return res;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       hit;
    n   = 6'd48;
    hit = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (v[i] && !hit) begin
        n   = 6'(47 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       hit;
    n   = 5'd27;
    hit = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (v[i] && !hit) begin
        n   = 5'(26 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // stage 1 registers
  logic               s1_valid_r;
  fpu_op_t            s1_op_r;
  logic               s1_spec_r;
  logic [31:0]        s1_spec_val_r;
  logic               s1_sign_r;
  logic               s1_sub_r;
  logic signed [11:0] s1_exp_r;
  logic [47:0]        s1_prod_r;
  logic [26:0]        s1_ma_r;
  logic [26:0]        s1_mb_r;

  logic               s2_valid_r;
  logic [31:0]        s2_res_r;

  // stage 1: unpack, specials, product or alignment
  logic               sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [7:0]         ea, eb, eae, ebe;
  logic [23:0]        ma, mb;
  logic               spec_nxt;
  logic [31:0]        spec_val_nxt;
  logic               sign_nxt;
  logic signed [11:0] exp_nxt;
  logic               swap;
  logic [7:0]         dexp;
  logic [26:0]        big27, small27, al27;

  always_comb begin
    sa     = req.a[31];
    sb     = req.b[31];
    ea     = req.a[30:23];
    eb     = req.b[30:23];
    a_nan  = (ea == 8'hFF) && (req.a[22:0] != 23'd0);
    b_nan  = (eb == 8'hFF) && (req.b[22:0] != 23'd0);
    a_inf  = (ea == 8'hFF) && (req.a[22:0] == 23'd0);
    b_inf  = (eb == 8'hFF) && (req.b[22:0] == 23'd0);
    a_zero = req.a[30:0] == 31'd0;
    b_zero = req.b[30:0] == 31'd0;
    ma     = {ea != 8'd0, req.a[22:0]};
    mb     = {eb != 8'd0, req.b[22:0]};
    eae    = (ea == 8'd0) ? 8'd1 : ea;
    ebe    = (eb == 8'd0) ? 8'd1 : eb;
    swap   = req.b[30:0] > req.a[30:0];
    big27   = swap ? {mb, 3'b000} : {ma, 3'b000};
    small27 = swap ? {ma, 3'b000} : {mb, 3'b000};
    dexp    = swap ? (ebe - eae) : (eae - ebe);
    if (dexp >= 8'd27) begin
      al27 = {26'd0, |small27};
    end else begin
      al27 = (small27 >> dexp) | {26'd0, |(small27 & ~({27{1'b1}} << dexp))};
    end
    spec_nxt     = 1'b0;
    spec_val_nxt = QNAN_BITS;
    if (req.op == FPU_MUL) begin
      sign_nxt = sa ^ sb;
      exp_nxt  = $signed({4'd0, eae}) + $signed({4'd0, ebe}) - 12'sd126;
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
        spec_nxt = 1'b1;
      end else if (a_inf || b_inf) begin
        spec_nxt     = 1'b1;
        spec_val_nxt = {sa ^ sb, 8'hFF, 23'd0};
      end
    end else begin
      sign_nxt = swap ? sb : sa;
      exp_nxt  = $signed({4'd0, (swap ? ebe : eae)});
      if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) begin
        spec_nxt = 1'b1;
      end else if (a_inf) begin
        spec_nxt     = 1'b1;
        spec_val_nxt = req.a;
      end else if (b_inf) begin
        spec_nxt     = 1'b1;
        spec_val_nxt = req.b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= req.valid;
    end
    s1_op_r       <= req.op;
    s1_spec_r     <= spec_nxt;
    s1_spec_val_r <= spec_val_nxt;
    s1_sign_r     <= sign_nxt;
    s1_sub_r      <= sa ^ sb;
    s1_exp_r      <= exp_nxt;
    s1_prod_r     <= ma * mb;
    s1_ma_r       <= big27;
    s1_mb_r       <= al27;
  end

  // stage 2: normalize and round
  logic [27:0]        sum28;
  logic [26:0]        r27;
  logic [4:0]         lz_a;
  logic [4:0]         sh_a;
  logic [5:0]         lz_m;
  logic [47:0]        q2;
  logic               stk_m;
  logic signed [11:0] e_out;
  logic signed [11:0] rsh;
  logic               sgn_out;
  logic [31:0]        res_nxt;

  always_comb begin
    sum28   = 28'd0;
    r27     = 27'd0;
    lz_a    = 5'd0;
    sh_a    = 5'd0;
    lz_m    = 6'd0;
    q2      = 48'd0;
    stk_m   = 1'b0;
    rsh     = 12'sd0;
    e_out   = s1_exp_r;
    sgn_out = s1_sign_r;
    if (s1_spec_r) begin
      res_nxt = s1_spec_val_r;
    end else if (s1_op_r == FPU_MUL) begin
      lz_m = lzc48(s1_prod_r);
      if (s1_prod_r == 48'd0) begin
        res_nxt = {s1_sign_r, 31'd0};
      end else begin
        if (s1_exp_r - $signed({6'd0, lz_m}) >= 12'sd1) begin
          q2    = s1_prod_r << lz_m;
          e_out = s1_exp_r - $signed({6'd0, lz_m});
        end else if (s1_exp_r >= 12'sd1) begin
          q2    = s1_prod_r << s1_exp_r[5:0] - 6'd1;
          e_out = 12'sd1;
        end else begin
          rsh   = 12'sd1 - s1_exp_r;
          e_out = 12'sd1;
          if (rsh >= 12'sd48) begin
            q2    = 48'd0;
            stk_m = 1'b1;
          end else begin
            q2    = s1_prod_r >> rsh[5:0];
            stk_m = |(s1_prod_r & ~({48{1'b1}} << rsh[5:0]));
          end
        end
        res_nxt = round_pack(s1_sign_r, e_out, q2[47:24], q2[23], (|q2[22:0]) | stk_m);
      end
    end else begin
      sum28 = s1_sub_r ? ({1'b0, s1_ma_r} - {1'b0, s1_mb_r})
                       : ({1'b0, s1_ma_r} + {1'b0, s1_mb_r});
      // exact cancellation gives +0
      if (s1_sub_r && (sum28 == 28'd0)) begin
        sgn_out = 1'b0;
      end
      if (sum28[27]) begin
        r27   = {sum28[27:2], sum28[1] | sum28[0]};
        e_out = s1_exp_r + 12'sd1;
      end else begin
        lz_a = lzc27(sum28[26:0]);
        // stop at the subnormal exponent
        if ($signed({7'd0, lz_a}) < s1_exp_r - 12'sd1) begin
          sh_a = lz_a;
        end else begin
          sh_a = 5'(s1_exp_r - 12'sd1);
        end
        r27   = sum28[26:0] << sh_a;
        e_out = s1_exp_r - $signed({7'd0, sh_a});
      end
      res_nxt = round_pack(sgn_out, e_out, r27[26:3], r27[2], |r27[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_res_r <= res_nxt;
  end

  assign rsp.done   = s2_valid_r;
  assign rsp.result = s2_res_r;

endmodule

### rtl/kvm_checker.sv
// port-level checks for the compensated vector-matrix product block
// depends on kvm_pkg; bound to kahan_vector_matrix_product
module kvm_checker
  import kvm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  out_index,
  input logic [31:0] out_value,
  input logic        out_last,
  input logic        out_mismatch
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_index))
    else $error("result changed while stalled");

  a_mismatch_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mismatch |-> out_last && (out_index == 6'd0) && (out_value == 32'd0))
    else $error("mismatch result malformed");

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_COMPUTE) |=> !in_ready)
    else $error("compute transaction did not hold off input");

  a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_value[30:23] == 8'hFF) && (out_value[22:0] != 23'd0)
      |-> out_value == QNAN_BITS)
    else $error("non-canonical nan on output");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind kahan_vector_matrix_product kvm_checker u_kvm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_action    (in_chan.action),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_index    (out_chan.out_index),
  .out_value    (out_chan.out_value),
  .out_last     (out_chan.last),
  .out_mismatch (out_chan.mismatch)
);

### tb/sv/kahan_vector_matrix_product_tb.sv
// testbench for the compensated vector-matrix product block
// depends on kvm_pkg, kvm_in_if, kvm_out_if and the kahan_vector_matrix_product rtl
// a scoreboard class predicts each column sum in binary32 and checks every result
`timescale 1ns / 100ps

module kahan_vector_matrix_product_tb;
  import kvm_pkg::*;

  localparam int N_MAX       = 64;
  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 1600;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic [5:0]  index;
    logic [31:0] value;
    logic        last;
    logic        mismatch;
  } col_result_t;

  // binary32 <-> binary64; double arithmetic rounded once to single is exact for + - *
  function automatic real f32_to_real(logic [31:0] f);
    logic [63:0] b;
    logic [23:0] m;
    int ex;
    if (f[30:23] == 8'hFF) begin
      b = {f[31], 11'h7FF, f[22:0], 29'd0};
    end else if (f[30:23] == 8'h00) begin
      if (f[22:0] == 0) begin
        b = {f[31], 63'd0};
      end else begin
        m = {1'b0, f[22:0]};
        ex = -126;
        while (!m[23]) begin
          m = m << 1;
          ex--;
        end
        b = {f[31], 11'(ex + 1023), m[22:0], 29'd0};
      end
    end else begin
      b = {f[31], 11'(int'(f[30:23]) + 896), f[22:0], 29'd0};
    end
    return $bitstoreal(b);
  endfunction

  function automatic logic [31:0] real_to_f32(real r);
    logic [63:0] b;
    logic [63:0] q, rem, half;
    logic s;
    int x, sh;
    b = $realtobits(r);
    s = b[63];
    if (b[62:52] == 11'h7FF) return (b[51:0] != 0) ? QNAN_BITS : {s, 8'hFF, 23'd0};
    if (b[62:52] == 11'd0) return {s, 31'd0};
    x = int'(b[62:52]) - 1023;
    if (x > 127) return {s, 8'hFF, 23'd0};
    sh = (x >= -126) ? 29 : -97 - x;
    if (sh > 54) return {s, 31'd0};
    q    = {11'd0, 1'b1, b[51:0]} >> sh;
    rem  = {11'd0, 1'b1, b[51:0]} & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    if (x >= -126) begin
      if (q[24]) begin
        q = q >> 1;
        x++;
      end
      if (x > 127) return {s, 8'hFF, 23'd0};
      return {s, 8'(x + 127), q[22:0]};
    end
    // subnormal, or rounded up into the smallest normal
    return {s, q[30:0]};
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    return real_to_f32(f32_to_real(a) * f32_to_real(b));
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    return real_to_f32(f32_to_real(a) + f32_to_real(b));
  endfunction

  function automatic logic [31:0] fp_sub(logic [31:0] a, logic [31:0] b);
    return real_to_f32(f32_to_real(a) - f32_to_real(b));
  endfunction

  class kvm_scoreboard;
    logic [31:0] vec_mem [N_MAX];
    logic [31:0] mat_mem [N_MAX*N_MAX];
    logic [6:0]  inner_len, matrix_rows, out_len;
    col_result_t sums_q [$];
    int errors, n_results, n_computes;

    function new();
      foreach (vec_mem[i]) vec_mem[i] = '0;
      foreach (mat_mem[i]) mat_mem[i] = '0;
      inner_len = 7'd64;
      matrix_rows = 7'd64;
      out_len = 7'd64;
    endfunction

    function void set_reg(logic [1:0] idx, logic [6:0] v);
      case (idx)
        CFG_INNER_LEN:   inner_len = v;
        CFG_MATRIX_ROWS: matrix_rows = v;
        CFG_OUT_LEN:     out_len = v;
        default: ;
      endcase
    endfunction

    function logic [31:0] column_sum(int col, int n);
      logic [31:0] s, c, p, y, t, d;
      s = '0;
      c = '0;
      for (int k = 0; k < n; k++) begin
        p = fp_mul(vec_mem[k], mat_mem[k*N_MAX + col]);
        y = fp_sub(p, c);
        t = fp_add(s, y);
        d = fp_sub(t, s);
        c = fp_sub(d, y);
        s = t;
      end
      return s;
    endfunction

    function void note_input(logic [1:0] act, logic [5:0] row, logic [5:0] col,
                             logic [31:0] val);
      col_result_t r;
      int n, cols;
      if (act == ACT_LOAD_VEC) begin
        vec_mem[row] = val;
      end else if (act == ACT_LOAD_MAT) begin
        mat_mem[row*N_MAX + col] = val;
      end else if (act == ACT_COMPUTE) begin
        n_computes++;
        if (inner_len != matrix_rows) begin
          r.index = '0;
          r.value = '0;
          r.last = 1'b1;
          r.mismatch = 1'b1;
          sums_q.push_back(r);
        end else begin
          n = (inner_len > N_MAX) ? N_MAX : inner_len;
          cols = (out_len > N_MAX) ? N_MAX : out_len;
          for (int j = 0; j < cols; j++) begin
            r.index = 6'(j);
            r.value = column_sum(j, n);
            r.last = (j + 1 == cols);
            r.mismatch = 1'b0;
            sums_q.push_back(r);
          end
        end
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task check_result(logic [5:0] idx, logic [31:0] val, logic lst, logic mis);
      col_result_t e;
      n_results++;
      if (sums_q.size() == 0) begin
        report("unexpected result index", 32'(idx), 32'd0);
        return;
      end
      e = sums_q.pop_front();
      if (idx !== e.index) report("out_index", 32'(idx), 32'(e.index));
      if (val !== e.value) report("out_value", val, e.value);
      if (lst !== e.last) report("last", 32'(lst), 32'(e.last));
      if (mis !== e.mismatch) report("mismatch", 32'(mis), 32'(e.mismatch));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_wdata;
  logic       hold_req;
  int         idle_cnt;
  int         items_sent;
  bit         vec_written [N_MAX];
  bit         mat_written [N_MAX*N_MAX];

  kvm_scoreboard sb;

  kvm_in_if  in_chan ();
  kvm_out_if out_chan ();

  kahan_vector_matrix_product u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_fp();
    case ($urandom_range(0, 11))
      0:       return $urandom();
      1:       return {1'($urandom), 31'd0};
      2:       return {1'($urandom), 8'hFF, 23'd0};
      3:       return {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
      4:       return {1'($urandom), 8'h00, 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(107, 147)), 23'($urandom)};
    endcase
  endfunction

  // monitors and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        sb.note_input(in_chan.action, in_chan.row_index, in_chan.col_index,
                      in_chan.value_bits);
      if (out_chan.valid && out_chan.ready)
        sb.check_result(out_chan.out_index, out_chan.out_value, out_chan.last,
                        out_chan.mismatch);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
        if (idle_cnt + 1 >= IDLE_LIMIT) begin
          $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // result receiver with random stalls and one long hold-off on request
  initial begin
    int gap;
    out_chan.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req <= 1'b0;
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  task automatic send_item(logic [1:0] act, logic [5:0] row, logic [5:0] col,
                           logic [31:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.action     <= act;
    in_chan.row_index  <= row;
    in_chan.col_index  <= col;
    in_chan.value_bits <= val;
    do @(posedge clk); while (!in_chan.ready);
    if (act == ACT_LOAD_VEC) vec_written[row] = 1'b1;
    if (act == ACT_LOAD_MAT) mat_written[row*N_MAX + col] = 1'b1;
    items_sent++;
  endtask

  // write enable drops for a cycle so back-to-back writes never overlap
  task automatic write_cfg(logic [1:0] idx, logic [6:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (sb.sums_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // make sure a compute never reads a slot that was never loaded
  task automatic load_missing(int n, int cols);
    for (int k = 0; k < n; k++) begin
      if (!vec_written[k]) send_item(ACT_LOAD_VEC, 6'(k), 6'($urandom), rand_fp());
      for (int j = 0; j < cols; j++)
        if (!mat_written[k*N_MAX + j]) send_item(ACT_LOAD_MAT, 6'(k), 6'(j), rand_fp());
    end
  endtask

  task automatic run_random(int count, int n, int cols);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55 && n > 0 && cols > 0) begin
        if ($urandom_range(0, 1))
          send_item(ACT_LOAD_VEC, 6'($urandom_range(0, n - 1)), 6'($urandom), rand_fp());
        else
          send_item(ACT_LOAD_MAT, 6'($urandom_range(0, n - 1)),
                    6'($urandom_range(0, cols - 1)), rand_fp());
      end else if (r < 70) begin
        send_item($urandom_range(0, 1) ? ACT_LOAD_MAT : ACT_LOAD_VEC, 6'($urandom),
                  6'($urandom), rand_fp());
      end else if (r < 93) begin
        send_item(ACT_COMPUTE, 6'($urandom), 6'($urandom), $urandom());
      end else begin
        // unused action code, must be ignored
        send_item(2'd3, 6'($urandom), 6'($urandom), $urandom());
      end
    end
  endtask

  task automatic run_phase(logic [6:0] inner, logic [6:0] rows, logic [6:0] outl,
                           int count);
    int n, cols;
    drain();
    write_cfg(CFG_INNER_LEN, inner);
    write_cfg(CFG_MATRIX_ROWS, rows);
    write_cfg(CFG_OUT_LEN, outl);
    n = (inner > N_MAX) ? N_MAX : inner;
    cols = (outl > N_MAX) ? N_MAX : outl;
    if (inner == rows) load_missing(n, cols);
    send_item(ACT_COMPUTE, '0, '0, '0);
    run_random(count, (inner == rows) ? n : 0, cols);
  endtask

  initial begin
    logic [6:0] rn, rr, ro;
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_req = 1'b0;
    idle_cnt = 0;
    items_sent = 0;
    in_chan.valid = 1'b0;
    in_chan.action = ACT_LOAD_VEC;
    in_chan.row_index = '0;
    in_chan.col_index = '0;
    in_chan.value_bits = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme operand patterns on a 4 x 3 product
    write_cfg(CFG_INNER_LEN, 7'd4);
    write_cfg(CFG_MATRIX_ROWS, 7'd4);
    write_cfg(CFG_OUT_LEN, 7'd3);
    send_item(ACT_LOAD_VEC, 6'd0, 6'd63, 32'h3F80_0000);
    send_item(ACT_LOAD_VEC, 6'd1, 6'd0, 32'h7F7F_FFFF);
    send_item(ACT_LOAD_VEC, 6'd2, 6'd0, 32'h0000_0001);
    send_item(ACT_LOAD_VEC, 6'd3, 6'd0, 32'hBF80_0000);
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 3; j++)
        send_item(ACT_LOAD_MAT, 6'(k), 6'(j),
                  (k == 1 && j == 2) ? 32'h7F7F_FFFF : (k == 2) ? 32'h8000_0000 :
                  {1'(j), 8'd127, 23'(k * 32'h10_0001)});
    send_item(ACT_COMPUTE, 6'd63, 6'd63, 32'hFFFF_FFFF);
    send_item(2'd3, 6'd63, 6'd63, 32'hFFFF_FFFF);
    send_item(ACT_LOAD_MAT, 6'd63, 6'd63, 32'hFFFF_FFFF);
    send_item(ACT_LOAD_VEC, 6'd63, 6'd63, 32'h7FC0_0001);
    send_item(ACT_LOAD_MAT, 6'd0, 6'd1, 32'h7F80_0000);
    send_item(ACT_COMPUTE, '0, '0, '0);

    run_phase(7'd5, 7'd6, 7'd2, 4);       // length mismatch
    run_phase(7'd0, 7'd0, 7'd2, 4);       // empty sums
    run_phase(7'd3, 7'd3, 7'd0, 4);       // no columns at all
    run_phase(7'd127, 7'd127, 7'd1, 3);   // inner length saturates
    run_phase(7'd1, 7'd1, 7'd127, 3);     // column count saturates
    run_phase(7'd127, 7'd64, 7'd2, 2);    // mismatch on raw compare

    // long receiver hold-off while the next phase keeps offering transactions
    drain();
    hold_req <= 1'b1;
    run_phase(7'd4, 7'd4, 7'd4, 20);

    while (items_sent < 230) begin
      rn = 7'($urandom_range(1, 8));
      rr = ($urandom_range(0, 6) == 0) ? 7'($urandom) : rn;
      ro = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 8));
      run_phase(rn, rr, ro, 15);
    end

    drain();
    $display("ran %0d input transactions, %0d computes, %0d results checked",
             items_sent, sb.n_computes, sb.n_results);
    $display("covered length mismatch, empty and saturated lengths, fp specials, stalls");
    if (sb.errors == 0 && sb.sums_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d errors, %0d results never seen", sb.errors, sb.sums_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
